// ===== sv/kli_pkg.sv =====
`default_nettype none

package kli_pkg;

    localparam int DATA_W           = 32;
    localparam int FRAC_W           = 16;
    localparam int INDEX_W          = 6;
    localparam int KEY_COUNT_W      = 7;
    localparam int DEFAULT_MAX_KEYS = 64;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 104;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
    } vec_t;

    typedef struct packed {
        logic [DATA_W-1:0] t;
        vec_t              v;
    } key_t;

endpackage

`default_nettype wire

// ===== sv/kli_key_mem.sv =====
`default_nettype none

module kli_key_mem
    import kli_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_KEYS,
    parameter int AW    = $clog2(DEFAULT_MAX_KEYS)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire key_t          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output key_t               rd_data
);

    key_t mem_reg [DEPTH];
    key_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/kli_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. Requires num < den.
module kli_divider
    import kli_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] num,
    input  wire logic [DATA_W-1:0] den,
    output logic                   busy,
    output logic                   done,
    output logic [FRAC_W-1:0]      quot
);

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [FRAC_W-1:0] quot_reg;

    logic [DATA_W:0]   shifted;
    logic              fits;
    logic [DATA_W:0]   diff;

    always_comb begin
        shifted = {rem_reg, 1'b0};
        fits    = (shifted >= {1'b0, den_reg});
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_W);
                rem_reg  <= num;
                den_reg  <= den;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                quot_reg <= {quot_reg[FRAC_W-2:0], fits};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== sv/kli_lerp.sv =====
`default_nettype none

// start + round(f * (end - start) / 2^16), one component at a time
// through a shared multiplier: subtract, multiply, round-and-add.
module kli_lerp
    import kli_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [FRAC_W-1:0] f,
    input  wire vec_t              v0,
    input  wire vec_t              v1,
    output logic                   done,
    output vec_t                   res
);

    localparam int DELTA_W = DATA_W + 1;
    localparam int PROD_W  = DELTA_W + FRAC_W + 1;

    typedef enum logic [1:0] {
        L_IDLE,
        L_SUB,
        L_MUL,
        L_ADD
    } phase_t;

    phase_t                     phase_reg;
    logic   [1:0]               comp_reg;
    logic                       done_reg;
    logic   [FRAC_W-1:0]        f_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    vec_t                       res_reg;

    logic [DATA_W-1:0]          s_sel;
    logic [DATA_W-1:0]          e_sel;
    logic signed [PROD_W-1:0]   rounded;
    logic [DATA_W-1:0]          comp_out;

    always_comb begin
        case (comp_reg)
            2'd0: begin
                s_sel = v0.x;
                e_sel = v1.x;
            end
            2'd1: begin
                s_sel = v0.y;
                e_sel = v1.y;
            end
            default: begin
                s_sel = v0.z;
                e_sel = v1.z;
            end
        endcase
        rounded  = prod_reg + PROD_W'(32768);
        // low word of start + floor(rounded / 2^16)
        comp_out = s_sel + rounded[FRAC_W+DATA_W-1:FRAC_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= L_IDLE;
            done_reg  <= 1'b0;
            comp_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                L_IDLE: begin
                    if (start) begin
                        f_reg     <= f;
                        comp_reg  <= '0;
                        phase_reg <= L_SUB;
                    end
                end
                L_SUB: begin
                    delta_reg <= $signed({e_sel[DATA_W-1], e_sel})
                               - $signed({s_sel[DATA_W-1], s_sel});
                    phase_reg <= L_MUL;
                end
                L_MUL: begin
                    prod_reg  <= $signed({1'b0, f_reg}) * delta_reg;
                    phase_reg <= L_ADD;
                end
                L_ADD: begin
                    case (comp_reg)
                        2'd0:    res_reg.x <= comp_out;
                        2'd1:    res_reg.y <= comp_out;
                        default: res_reg.z <= comp_out;
                    endcase
                    if (comp_reg == 2'd2) begin
                        done_reg  <= 1'b1;
                        phase_reg <= L_IDLE;
                    end else begin
                        comp_reg  <= comp_reg + 2'd1;
                        phase_reg <= L_SUB;
                    end
                end
                default: phase_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== sv/keyframe_linear_interpolator_unit.sv =====
// Key write: no result; the next request can follow on the next cycle.
// Query: linear scan of the key memory, one key per cycle (registered read),
// then a serial divide and shared-multiplier interpolation.
// A query holds off new requests until its result is loaded into the output register;
// a clamped query skips the divide and the interpolation.
// aresetn (synchronous) sets key_count to 1 and idles control; key memory is not cleared.
`default_nettype none

module keyframe_linear_interpolator_unit
    import kli_pkg::*;
#(
    parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [KEY_COUNT_W-1:0] cfg_data,   // key_count

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], query_time[165:134], zero pad
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   s_tuser,    // mode

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], interval_index[101:96], zero pad
    output logic [M_TDATA_W-1:0]        m_tdata,
    output logic                        m_tuser     // out_of_range
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int LW = ((AW > KEY_COUNT_W) ? AW : KEY_COUNT_W) + 1;
    localparam logic [LW-1:0] MAX_N = LW'(MAX_KEYS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_SCAN,
        ST_DIV,
        ST_LERP,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [KEY_COUNT_W-1:0] key_count_reg;
    logic [LW-1:0]          n_reg;
    logic [LW-1:0]          scan_reg;
    logic [DATA_W-1:0]      q_reg;
    key_t                   prev_reg;
    key_t                   end_reg;
    vec_t                   res_vec_reg;
    logic [INDEX_W-1:0]     res_idx_reg;
    logic                   res_flag_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   s_accept;
    logic                   s_mode;
    logic [INDEX_W-1:0]     s_key_index;
    logic [LW-1:0]          s_slot;
    key_t                   s_key;
    logic [DATA_W-1:0]      s_query_time;
    logic [LW-1:0]          kc_ext;
    logic [LW-1:0]          n_next;
    logic [LW-1:0]          scan_inc;
    logic [LW-1:0]          scan_dec;

    logic                   mem_wr_en;
    logic [AW-1:0]          mem_rd_addr;
    key_t                   mem_rd_data;

    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [FRAC_W-1:0]      div_quot;
    logic                   lerp_done;
    vec_t                   lerp_res;
    logic                   out_free;

    assign s_mode       = s_tuser;
    assign s_key_index  = s_tdata[5:0];
    assign s_key.t      = s_tdata[37:6];
    assign s_key.v.x    = s_tdata[69:38];
    assign s_key.v.y    = s_tdata[101:70];
    assign s_key.v.z    = s_tdata[133:102];
    assign s_query_time = s_tdata[165:134];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign s_slot    = LW'(s_key_index);
    assign mem_wr_en = s_accept && (s_mode == MODE_WRITE) && (s_slot < MAX_N);

    assign kc_ext   = LW'(key_count_reg);
    assign n_next   = (kc_ext == '0) ? LW'(1) : ((kc_ext > MAX_N) ? MAX_N : kc_ext);
    assign scan_inc = scan_reg + LW'(1);
    assign scan_dec = scan_reg - LW'(1);
    // address 0 while idle, then the key after the one now arriving
    assign mem_rd_addr = (state_reg == ST_IDLE) ? '0 : scan_inc[AW-1:0];

    assign div_start = (state_reg == ST_SCAN) && (q_reg < mem_rd_data.t)
                    && !(q_reg < prev_reg.t);
    assign out_free  = !m_tvalid_reg || m_tready;

    kli_key_mem #(
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (s_slot[AW-1:0]),
        .wr_data (s_key),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    kli_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (q_reg - prev_reg.t),
        .den     (mem_rd_data.t - prev_reg.t),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    kli_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_done),
        .f       (div_quot),
        .v0      (prev_reg.v),
        .v1      (end_reg.v),
        .done    (lerp_done),
        .res     (lerp_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_count_reg <= KEY_COUNT_W'(1);
            m_tvalid_reg  <= 1'b0;
            n_reg         <= LW'(1);
            scan_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                key_count_reg <= cfg_data;
            end
            // in ST_OUT the output register is reloaded instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_mode == MODE_QUERY)) begin
                        q_reg     <= s_query_time;
                        n_reg     <= n_next;
                        scan_reg  <= '0;
                        state_reg <= ST_RD0;
                    end
                end
                ST_RD0: begin
                    prev_reg <= mem_rd_data;
                    scan_reg <= LW'(1);
                    if (n_reg == LW'(1) || q_reg < mem_rd_data.t) begin
                        res_vec_reg  <= mem_rd_data.v;
                        res_idx_reg  <= '0;
                        res_flag_reg <= (n_reg != LW'(1));
                        state_reg    <= ST_OUT;
                    end else begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    res_idx_reg <= scan_dec[INDEX_W-1:0];
                    if (q_reg < mem_rd_data.t) begin
                        if (q_reg < prev_reg.t) begin
                            // times out of order: hold the interval start
                            res_vec_reg  <= prev_reg.v;
                            res_flag_reg <= 1'b1;
                            state_reg    <= ST_OUT;
                        end else begin
                            end_reg      <= mem_rd_data;
                            res_flag_reg <= 1'b0;
                            state_reg    <= ST_DIV;
                        end
                    end else if (scan_reg == n_reg - LW'(1)) begin
                        // past the last key
                        res_vec_reg  <= mem_rd_data.v;
                        res_flag_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end else begin
                        prev_reg <= mem_rd_data;
                        scan_reg <= scan_inc;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_LERP;
                    end
                end
                ST_LERP: begin
                    if (lerp_done) begin
                        res_vec_reg <= lerp_res;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(M_TDATA_W - 3*DATA_W - INDEX_W){1'b0}},
                                         res_idx_reg, res_vec_reg};
                        m_tuser_reg  <= res_flag_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (n_reg >= LW'(1) && n_reg <= MAX_N))
        else $error("key count out of range during query");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_reg >= LW'(1) && scan_reg < n_reg))
        else $error("scan index past key count");

endmodule

`default_nettype wire

// ===== verif/keyframe_linear_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

module keyframe_linear_interpolator_unit_tb;
    import kli_pkg::*;

    localparam int NUM_KEYS    = DEFAULT_MAX_KEYS;
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 110;

    typedef struct {
        logic               mode;
        logic [INDEX_W-1:0] slot;
        key_t               key;
        logic [DATA_W-1:0]  at;
    } kf_req_t;

    typedef struct {
        vec_t               v;
        logic [INDEX_W-1:0] seg;
        logic               clamped;
    } kf_sample_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [KEY_COUNT_W-1:0] cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    kf_req_t     key_requests[$];
    kf_sample_t  pending_samples[$];
    kf_req_t     held_req;
    kf_sample_t  due_sample;

    // predicted block state
    key_t        key_tbl[NUM_KEYS];
    int unsigned key_count_reg = 1;

    // stimulus bookkeeping
    logic [DATA_W-1:0] plan_time[NUM_KEYS];
    bit                plan_sorted;
    int                items_made   = 0;
    int                err_count    = 0;
    int                send_gap_pct = 0;
    int                recv_gap_pct = 0;
    int                stall_cycles = 0;

    int cfg_plan[15] = '{2, 64, 5, 127, 1, 33, 0, 64, 8, 2, 63, 3, 16, 64, 4};

    always #6 aclk = ~aclk;

    keyframe_linear_interpolator_unit #(
        .MAX_KEYS (NUM_KEYS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // start + round(f * (end - start) / 2^16), ties toward plus infinity
    function automatic logic [DATA_W-1:0] blend(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                logic [FRAC_W-1:0] f);
        longint sa, diff, prod;
        sa   = longint'($signed(a));
        diff = longint'($signed(b)) - sa;
        prod = longint'({48'h0, f}) * diff + 32768;
        return DATA_W'(sa + (prod >>> FRAC_W));
    endfunction

    function automatic kf_sample_t sample_at(logic [DATA_W-1:0] q);
        kf_sample_t          r;
        int unsigned         n;
        logic [DATA_W-1:0]   elapsed, span;
        logic [2*DATA_W-1:0] ratio;
        n = key_count_reg;
        if (n < 1) n = 1;
        if (n > NUM_KEYS) n = NUM_KEYS;
        r.v       = key_tbl[0].v;
        r.seg     = '0;
        r.clamped = 1'b0;
        if (n == 1) return r;
        if (q < key_tbl[0].t) begin
            r.clamped = 1'b1;
            return r;
        end
        for (int i = 0; i + 1 < n; i++) begin
            if (q < key_tbl[i+1].t) begin
                r.seg = INDEX_W'(i);
                r.v   = key_tbl[i].v;
                if (q < key_tbl[i].t) begin
                    r.clamped = 1'b1;
                    return r;
                end
                elapsed = q - key_tbl[i].t;
                span    = key_tbl[i+1].t - key_tbl[i].t;
                ratio   = {elapsed, {FRAC_W{1'b0}}} / {{DATA_W{1'b0}}, span};
                r.v.x   = blend(key_tbl[i].v.x, key_tbl[i+1].v.x, ratio[FRAC_W-1:0]);
                r.v.y   = blend(key_tbl[i].v.y, key_tbl[i+1].v.y, ratio[FRAC_W-1:0]);
                r.v.z   = blend(key_tbl[i].v.z, key_tbl[i+1].v.z, ratio[FRAC_W-1:0]);
                return r;
            end
        end
        // past the last key: hold it, report the last interval
        r.v       = key_tbl[n-1].v;
        r.seg     = INDEX_W'(n - 2);
        r.clamped = 1'b1;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        if (err_count < 40)
            $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic vec_t rand_vec();
        vec_t v;
        v.x = rand_word();
        v.y = rand_word();
        v.z = rand_word();
        return v;
    endfunction

    task automatic queue_write(int slot, logic [DATA_W-1:0] t, vec_t v);
        kf_req_t r;
        r.mode  = MODE_WRITE;
        r.slot  = INDEX_W'(slot);
        r.key.t = t;
        r.key.v = v;
        r.at    = $urandom();
        key_requests = {key_requests, r};
        plan_time[slot] = t;
        items_made++;
    endtask

    task automatic queue_query(logic [DATA_W-1:0] q);
        kf_req_t r;
        r.mode  = MODE_QUERY;
        r.slot  = INDEX_W'($urandom());
        r.key.t = $urandom();
        r.key.v = rand_vec();
        r.at    = q;
        key_requests = {key_requests, r};
        items_made++;
    endtask

    // fill keys 0..n-1; most tables ascending, some dense with repeats, a few unsorted
    task automatic load_table(int n);
        int                style;
        longint            width;
        logic [DATA_W-1:0] t;
        style       = $urandom_range(9);
        width       = 64'h1_0000_0000 / n;
        plan_sorted = (style != 0);
        for (int i = 0; i < n; i++) begin
            case (style)
                0:       t = $urandom();
                1:       t = (i == 0) ? $urandom_range(32'h0010_0000) :
                                        plan_time[i-1] + $urandom_range(2);
                2, 3:    t = DATA_W'(longint'(i) * width +
                                     $urandom_range(DATA_W'(width - 1)));
                default: t = (i == 0) ? $urandom_range(32'h0010_0000) :
                                        plan_time[i-1] + $urandom_range(32'h0004_0000, 1);
            endcase
            queue_write(i, t, rand_vec());
        end
    endtask

    task automatic queue_probe(int n);
        int                i;
        logic [DATA_W-1:0] span;
        if (n < 2 || !plan_sorted) begin
            queue_query($urandom());
            return;
        end
        i    = $urandom_range(n - 2);
        span = plan_time[i+1] - plan_time[i];
        case ($urandom_range(9))
            0:       queue_query($urandom());
            1:       queue_query($urandom_range(plan_time[0]));
            2:       queue_query(plan_time[n-1] + $urandom_range(3));
            3:       queue_query(plan_time[i]);
            default: queue_query(span == 0 ? plan_time[i] : plan_time[i] + $urandom() % span);
        endcase
    endtask

    // mostly keep a rewritten key between its neighbors so the table stays ascending, else write any time
    task automatic rewrite_key(int n);
        int                i;
        logic [DATA_W-1:0] lo, hi;
        i  = $urandom_range(n - 1);
        lo = (i > 0) ? plan_time[i-1] : '0;
        hi = (i < n - 1) ? plan_time[i+1] : 32'hFFFF_FFFF;
        if (plan_sorted && $urandom_range(4) != 0) begin
            queue_write(i, $urandom_range(hi, lo), rand_vec());
        end else begin
            plan_sorted = 1'b0;
            queue_write(i, $urandom(), rand_vec());
        end
    endtask

    task automatic wait_idle();
        while (key_requests.size() != 0 || s_tvalid || pending_samples.size() != 0)
            @(posedge aclk);
        // a trailing key write leaves nothing to wait for, so give the block time
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_key_count(int val);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= KEY_COUNT_W'(val);
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        key_count_reg = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int cfg_val);
        int n, stop_at;
        bit fresh;
        set_key_count(cfg_val);
        n       = (cfg_val < 1) ? 1 : (cfg_val > NUM_KEYS) ? NUM_KEYS : cfg_val;
        stop_at = items_made + PHASE_ITEMS;
        fresh   = 1'b1;
        while (items_made < stop_at) begin
            if (fresh || !plan_sorted || (n <= 16 && $urandom_range(9) == 0))
                load_table(n);
            fresh = 1'b0;
            repeat ($urandom_range(12, 4)) begin
                case ($urandom_range(19))
                    0, 1: rewrite_key(n);
                    2: begin
                        // slots outside the active range are free to change
                        if (n < NUM_KEYS)
                            queue_write($urandom_range(NUM_KEYS - 1, n), $urandom(), rand_vec());
                        else
                            rewrite_key(n);
                    end
                    3:       queue_query($urandom());
                    default: queue_probe(n);
                endcase
            end
        end
    endtask

    // request driver and predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (held_req.mode == MODE_WRITE)
                    key_tbl[held_req.slot] = held_req.key;
                else
                    pending_samples = {pending_samples, sample_at(held_req.at)};
            end
            if (!s_tvalid || s_tready) begin
                if (key_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    held_req = key_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= held_req.mode;
                    s_tdata  <= {{(S_TDATA_W - 5*DATA_W - INDEX_W){1'b0}},
                                 held_req.at, held_req.key.v.z, held_req.key.v.y,
                                 held_req.key.v.x, held_req.key.t, held_req.slot};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_samples.size() == 0) begin
                    flag_mismatch("unexpected result, out_x", m_tdata[31:0], '0);
                end else begin
                    due_sample = pending_samples.pop_front();
                    if (m_tdata[31:0] !== due_sample.v.x)
                        flag_mismatch("out_x", m_tdata[31:0], due_sample.v.x);
                    if (m_tdata[63:32] !== due_sample.v.y)
                        flag_mismatch("out_y", m_tdata[63:32], due_sample.v.y);
                    if (m_tdata[95:64] !== due_sample.v.z)
                        flag_mismatch("out_z", m_tdata[95:64], due_sample.v.z);
                    if (m_tdata[101:96] !== due_sample.seg)
                        flag_mismatch("interval_index", DATA_W'(m_tdata[101:96]),
                                      DATA_W'(due_sample.seg));
                    if (m_tuser !== due_sample.clamped)
                        flag_mismatch("out_of_range", DATA_W'(m_tuser),
                                      DATA_W'(due_sample.clamped));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        send_gap_pct = 22;
        recv_gap_pct = 45;

        // single key at the reset count
        queue_write(0, 32'h0001_0000, '{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: '0});
        queue_query('0);
        queue_query(32'h0001_0000);
        queue_query(32'hFFFF_FFFF);

        // three keys with full-range deltas: before, on and between keys, at the end
        set_key_count(3);
        queue_write(0, 32'h0001_0000, '{x: 32'h8000_0000, y: 32'h7FFF_FFFF, z: 32'h1234_5678});
        queue_write(1, 32'h0002_0000, '{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'h1234_5678});
        queue_write(2, 32'hFFFF_FFFF, '{x: '0, y: 32'hFFFF_FFFF, z: 32'h0000_0001});
        queue_query('0);
        queue_query(32'h0001_0000);
        queue_query(32'h0001_8000);
        queue_query(32'h0001_FFFF);
        queue_query(32'h0002_0000);
        queue_query(32'h8000_0000);
        queue_query(32'hFFFF_FFFE);
        queue_query(32'hFFFF_FFFF);

        // count zero behaves as one key
        set_key_count(0);
        queue_query(32'h1234_5678);

        // two keys at the same time: the interval never matches
        set_key_count(2);
        queue_write(1, 32'h0001_0000, '{x: 32'h0000_0001, y: '0, z: 32'hFFFF_FFFF});
        queue_query(32'h0000_FFFF);
        queue_query(32'h0001_0000);

        for (int p = 0; p < 15; p++) begin
            if (p == 5) begin
                send_gap_pct = 45;
                recv_gap_pct = 22;
            end else if (p == 10) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            run_phase(cfg_plan[p]);
        end

        wait_idle();
        if (pending_samples.size() != 0)
            flag_mismatch("results never returned", DATA_W'(pending_samples.size()), '0);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
